// ===== hw/rtl/rlbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbd_pkg
// Shared constants for the resistor-ladder button debounce unit.
// ----------------------------------------------------------------------------
package rlbd_pkg;

  localparam int LEVEL_W    = 10;
  localparam int TIME_W     = 32;
  localparam int PRESS_W    = TIME_W + 1;   // press start never wraps
  localparam int COUNT_W    = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int LEVEL_REGS = 6;
  localparam int MAX_LEVELS = 6;

  localparam int DEBOUNCE_MS = 50;
  localparam int REPEAT_MS   = 250;

  localparam int IN_TDATA_W  = 48;          // sample + time_ms, byte padded
  localparam int OUT_TDATA_W = 16;          // level, byte padded

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_LEVEL = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_COUNT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_A       = 3'd2;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

endpackage

// ===== hw/rtl/resistor_ladder_button_debounce_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resistor_ladder_button_debounce_unit
// Classifies ladder ADC samples to the nearest level, debounces presses
// and auto-repeats; read transactions return and clear the latched level.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | slave     | tvalid/tready      | tdata {time_ms, sample}, tuser kind
//  out_    | master    | tvalid/tready      | tdata level, tuser at_default
//  cfg_    | write     | cfg_we             | cfg_addr, cfg_wdata
//
// One transaction per cycle sustained while the output is not stalled; an accepted
// item is held in the input register, then moves to the result register when the
// output can take it.
// Classification, timer compare and state update all happen in the cycle an
// item moves from the input register to the result register.
// rst_n is synchronous; it clears control state and config registers.
// A stalled output holds the result; the input register still takes one more
// transaction, then in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module resistor_ladder_button_debounce_unit
  import rlbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] sample, [41:10] time_ms, rest 0
  input  logic                   in_tuser,   // [0] kind
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] level, rest 0
  output logic                   out_tuser,  // [0] at_default
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [LEVEL_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [LEVEL_W-1:0] default_level_r;
  logic [COUNT_W-1:0] level_count_r;
  logic [LEVEL_W-1:0] ladder_r [LEVEL_REGS];

  // input register
  logic               s1_valid_r;
  logic               s1_kind_r;
  logic [LEVEL_W-1:0] s1_sample_r;
  logic [TIME_W-1:0]  s1_time_r;

  // block state
  logic [LEVEL_W-1:0] current_level_r, current_level_nxt;
  logic               current_known_r, current_known_nxt;
  logic [LEVEL_W-1:0] latched_level_r, latched_level_nxt;
  logic [PRESS_W-1:0] press_start_r,   press_start_nxt;

  // result register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic               out_at_def_r;

  logic               advance;
  logic [COUNT_W-1:0] n_use;
  logic [LEVEL_W:0]   mid_sum [LEVEL_REGS-1];
  logic [LEVEL_W-1:0] cls_level;
  logic               found;
  logic [PRESS_W-1:0] ps_mid;
  logic [PRESS_W:0]   elapsed;
  logic               repeat_hit;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_level_r <= '0;
      level_count_r   <= COUNT_W'(1);
      for (int i = 0; i < LEVEL_REGS; i++) ladder_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_DEFAULT_LEVEL) default_level_r <= cfg_wdata;
      if (cfg_addr == REG_LEVEL_COUNT)   level_count_r   <= cfg_wdata[COUNT_W-1:0];
      for (int i = 0; i < LEVEL_REGS; i++) begin
        if (cfg_addr == CFG_ADDR_W'(int'(REG_LEVEL_A) + i)) ladder_r[i] <= cfg_wdata;
      end
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r   <= in_tuser;
      s1_sample_r <= in_tdata[LEVEL_W-1:0];
      s1_time_r   <= in_tdata[LEVEL_W +: TIME_W];
    end
  end

  // ---------------- classification ----------------
  always_comb begin
    // zero counts as one, seven saturates
    n_use = level_count_r;
    if (n_use == '0) n_use = COUNT_W'(1);
    if (n_use > COUNT_W'(MAX_LEVELS)) n_use = COUNT_W'(MAX_LEVELS);

    for (int i = 0; i < LEVEL_REGS - 1; i++) begin
      mid_sum[i] = {1'b0, ladder_r[i]} + {1'b0, ladder_r[i+1]};
    end

    // top level in use is the fallback
    cls_level = ladder_r[0];
    for (int i = 1; i < LEVEL_REGS; i++) begin
      if (COUNT_W'(i) < n_use) cls_level = ladder_r[i];
    end

    // first level whose midpoint with the next level lies above the sample
    found = 1'b0;
    for (int i = 0; i < LEVEL_REGS - 1; i++) begin
      if (!found && (COUNT_W'(i + 1) < n_use) && (s1_sample_r < mid_sum[i][LEVEL_W:1])) begin
        cls_level = ladder_r[i];
        found     = 1'b1;
      end
    end
  end

  // ---------------- press timer and latch ----------------
  always_comb begin
    current_level_nxt = current_level_r;
    current_known_nxt = current_known_r;
    latched_level_nxt = latched_level_r;
    ps_mid            = press_start_r;
    press_start_nxt   = press_start_r;
    elapsed           = '0;
    repeat_hit        = 1'b0;
    out_level_nxt     = cls_level;

    if (s1_kind_r == KIND_READ) begin
      out_level_nxt     = latched_level_r;
      latched_level_nxt = default_level_r;
    end else begin
      if ((!current_known_r || current_level_r != default_level_r) &&
          cls_level == default_level_r) begin
        // release back to idle level
        ps_mid            = '0;
        current_level_nxt = cls_level;
        current_known_nxt = 1'b1;
        latched_level_nxt = cls_level;
      end else if (!current_known_r || current_level_r != cls_level) begin
        ps_mid            = {1'b0, s1_time_r};
        current_level_nxt = cls_level;
        current_known_nxt = 1'b1;
      end

      // signed time difference, one bit wider than press start
      elapsed    = {2'b00, s1_time_r} - {1'b0, ps_mid};
      repeat_hit = (cls_level != default_level_r) &&
                   ($signed(elapsed) > $signed((PRESS_W+1)'(DEBOUNCE_MS)));

      press_start_nxt = ps_mid;
      if (repeat_hit) begin
        press_start_nxt   = {1'b0, s1_time_r} + PRESS_W'(REPEAT_MS);
        latched_level_nxt = cls_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_level_r <= '0;
      current_known_r <= 1'b0;
      latched_level_r <= '0;
      press_start_r   <= '0;
    end else if (advance) begin
      current_level_r <= current_level_nxt;
      current_known_r <= current_known_nxt;
      latched_level_r <= latched_level_nxt;
      press_start_r   <= press_start_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level_r  <= out_level_nxt;
      out_at_def_r <= (out_level_nxt == default_level_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-LEVEL_W){1'b0}}, out_level_r};
  assign out_tuser  = out_at_def_r;

  // ---------------- assertions ----------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled while pipeline can move");

  a_known_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    current_known_r |=> current_known_r)
    else $error("current_known dropped outside reset");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item produced no result");

  a_read_clears_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_kind_r == KIND_READ) |=> (latched_level_r == $past(default_level_r)))
    else $error("read did not clear latched level to default");

endmodule
